### src/bmb_pkg.sv
`timescale 1ns / 1ps

package bmb_pkg;

  localparam int unsigned SectorW = 48;
  localparam int unsigned CountW  = 16;
  localparam int unsigned IndexW  = 6;

  typedef enum logic [1:0] {
    KIND_SUBMIT = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_REMAIN = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_HEAD_RD,
    ST_HEAD,
    ST_RUN,
    ST_EMIT,
    ST_DONE
  } state_e;

  // One stored request
  typedef struct packed {
    logic [SectorW-1:0] start;
    logic [CountW-1:0]  len;
    logic               wr;
  } entry_t;

  // One result item
  typedef struct packed {
    kind_e              kind;
    logic [IndexW-1:0]  first_index;
    logic [IndexW-1:0]  merged_count;
    logic [SectorW-1:0] io_start;
    logic [CountW-1:0]  io_count;
    logic               tail_split;
    logic [IndexW-1:0]  remain_index;
    logic [SectorW-1:0] resume;
    logic               last;
  } res_t;

endpackage

### src/bmb_if.sv
`timescale 1ns / 1ps

interface bmb_req_if;
  logic        valid;
  logic        ready;
  logic [47:0] req_start_sector;
  logic [15:0] req_sector_count;
  logic        req_is_write;
  logic [47:0] batch_resume_sector;
  logic        force_flush;
  logic        batch_last;

  modport source (
    output valid, req_start_sector, req_sector_count, req_is_write,
           batch_resume_sector, force_flush, batch_last,
    input  ready
  );
  modport sink (
    input  valid, req_start_sector, req_sector_count, req_is_write,
           batch_resume_sector, force_flush, batch_last,
    output ready
  );
endinterface

interface bmb_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [5:0]  first_index;
  logic [5:0]  merged_count;
  logic [47:0] io_start_sector;
  logic [15:0] io_sector_count;
  logic        tail_split;
  logic [5:0]  remain_index;
  logic [47:0] resume_sector;
  logic        last;

  modport source (
    output valid, result_kind, first_index, merged_count, io_start_sector,
           io_sector_count, tail_split, remain_index, resume_sector, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, first_index, merged_count, io_start_sector,
           io_sector_count, tail_split, remain_index, resume_sector, last,
    output ready
  );
endinterface

### src/bmb_store.sv
`timescale 1ns / 1ps

module bmb_store #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  bmb_pkg::entry_t     wr_data_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output bmb_pkg::entry_t     rd_data_o
);

  bmb_pkg::entry_t mem [Depth];
  bmb_pkg::entry_t rd_q;

  // Write one request per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

### src/bmb_ctrl.sv
`timescale 1ns / 1ps

module bmb_ctrl #(
  parameter int unsigned MaxBatch = 32,
  parameter int unsigned AddrW    = 5,
  parameter int unsigned CntW     = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         max_merge_i,
  bmb_req_if.sink             req_i,
  bmb_res_if.source           res_o,
  output logic                wr_en_o,
  output logic [AddrW-1:0]    wr_addr_o,
  output bmb_pkg::entry_t     wr_data_o,
  output logic [AddrW-1:0]    rd_addr_o,
  input  bmb_pkg::entry_t     rd_data_i
);

  localparam logic [CntW-1:0] MaxN = CntW'(MaxBatch);
  localparam logic [CntW-1:0] One  = CntW'(1);

  bmb_pkg::state_e state_q, state_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic [CntW-1:0]   n_q, n_d;
  logic [47:0]       sect_q, sect_d;
  logic              force_q, force_d;
  logic              use_start_q, use_start_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [AddrW-1:0]  i_q, i_d;
  logic [CntW-1:0]   mlen_q, mlen_d;
  logic [15:0]       slen_q, slen_d;
  logic              split_q, split_d;
  logic              cur_wr_q, cur_wr_d;
  bmb_pkg::entry_t   prev_q, prev_d;
  logic              out_valid_q, out_valid_d;
  bmb_pkg::res_t     out_q, out_d;

  logic [48:0]       pend;
  logic              in_run;
  logic [47:0]       sect_h;
  logic [15:0]       rem;
  logic [48:0]       prev_reach;
  logic              cont;
  logic [16:0]       nl;
  logic [CntW-1:0]   idx_ext;
  logic [CntW-1:0]   i_ext;
  logic [CntW-1:0]   mend_n;
  logic [CntW-1:0]   next;
  logic              hold;
  logic              out_free;

  // Head entry: locate the resume sector inside the request
  always_comb begin
    pend    = {1'b0, rd_data_i.start} + {33'b0, rd_data_i.len};
    in_run  = !use_start_q && (sect_q >= rd_data_i.start) && ({1'b0, sect_q} < pend);
    sect_h  = in_run ? sect_q : rd_data_i.start;
    rem     = 16'(pend - {1'b0, sect_h});
  end

  // Run extension: contiguity with the previous request and new length
  always_comb begin
    prev_reach = {1'b0, prev_q.start} + {33'b0, prev_q.len};
    cont       = (rd_data_i.wr == prev_q.wr) && ({1'b0, rd_data_i.start} == prev_reach);
    nl         = {1'b0, slen_q} + {1'b0, rd_data_i.len};
  end

  // IO close: hold-back rule and next index
  always_comb begin
    idx_ext = CntW'(idx_q);
    i_ext   = CntW'(i_q);
    mend_n  = idx_ext + mlen_q;
    next    = mend_n - CntW'(split_q);
    hold    = cur_wr_q && (slen_q < max_merge_i) && (mend_n == n_q) &&
              !((idx_q == '0) && ((n_q == MaxN) || force_q));
    out_free = !out_valid_q || res_o.ready;
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmb_pkg::ST_LOAD;
      fill_q      <= '0;
      n_q         <= '0;
      sect_q      <= '0;
      force_q     <= 1'b0;
      use_start_q <= 1'b0;
      idx_q       <= '0;
      i_q         <= '0;
      mlen_q      <= '0;
      slen_q      <= '0;
      split_q     <= 1'b0;
      cur_wr_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      n_q         <= n_d;
      sect_q      <= sect_d;
      force_q     <= force_d;
      use_start_q <= use_start_d;
      idx_q       <= idx_d;
      i_q         <= i_d;
      mlen_q      <= mlen_d;
      slen_q      <= slen_d;
      split_q     <= split_d;
      cur_wr_q    <= cur_wr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    out_q  <= out_d;
  end

  // Next state and datapath control
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    n_d         = n_q;
    sect_d      = sect_q;
    force_d     = force_q;
    use_start_d = use_start_q;
    idx_d       = idx_q;
    i_d         = i_q;
    mlen_d      = mlen_q;
    slen_d      = slen_q;
    split_d     = split_q;
    cur_wr_d    = cur_wr_q;
    prev_d      = prev_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_d       = out_q;
    req_i.ready = 1'b0;
    wr_en_o     = 1'b0;
    wr_addr_o   = fill_q[AddrW-1:0];
    wr_data_o   = '{start: req_i.req_start_sector, len: req_i.req_sector_count,
                    wr: req_i.req_is_write};
    rd_addr_o   = idx_q;

    case (state_q)
      bmb_pkg::ST_LOAD: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          if (fill_q < MaxN) begin
            wr_en_o = 1'b1;
            fill_d  = fill_q + One;
            if (fill_q == '0) begin
              sect_d      = req_i.batch_resume_sector;
              force_d     = req_i.force_flush;
              use_start_d = 1'b0;
            end
          end
          if (req_i.batch_last) begin
            n_d     = (fill_q < MaxN) ? fill_q + One : fill_q;
            idx_d   = '0;
            state_d = bmb_pkg::ST_HEAD_RD;
          end
        end
      end

      // Wait for the registered read of the first entry
      bmb_pkg::ST_HEAD_RD: begin
        rd_addr_o = idx_q;
        state_d   = bmb_pkg::ST_HEAD;
      end

      // Open an IO at the head entry
      bmb_pkg::ST_HEAD: begin
        rd_addr_o = idx_q + AddrW'(1);
        sect_d    = sect_h;
        slen_d    = rem;
        mlen_d    = One;
        split_d   = 1'b0;
        cur_wr_d  = rd_data_i.wr;
        prev_d    = rd_data_i;
        i_d       = idx_q + AddrW'(1);
        if (rd_data_i.wr && (rem < max_merge_i) && (idx_ext + One < n_q)) begin
          state_d = bmb_pkg::ST_RUN;
        end else begin
          state_d = bmb_pkg::ST_EMIT;
        end
      end

      // Extend the write run by one request per cycle
      bmb_pkg::ST_RUN: begin
        rd_addr_o = i_q + AddrW'(1);
        if (!cont) begin
          state_d = bmb_pkg::ST_EMIT;
        end else if (nl < {1'b0, max_merge_i}) begin
          slen_d = nl[15:0];
          mlen_d = mlen_q + One;
          prev_d = rd_data_i;
          if (i_ext + One < n_q) begin
            i_d = i_q + AddrW'(1);
          end else begin
            state_d = bmb_pkg::ST_EMIT;
          end
        end else begin
          split_d = nl > {1'b0, max_merge_i};
          slen_d  = max_merge_i;
          mlen_d  = mlen_q + One;
          state_d = bmb_pkg::ST_EMIT;
        end
      end

      // Emit the IO or the remainder, prefetch the next head
      bmb_pkg::ST_EMIT: begin
        rd_addr_o = next[AddrW-1:0];
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          if (hold) begin
            out_d.kind         = bmb_pkg::KIND_REMAIN;
            out_d.remain_index = bmb_pkg::IndexW'(idx_q);
            out_d.resume       = sect_q;
            out_d.last         = 1'b1;
            fill_d             = '0;
            state_d            = bmb_pkg::ST_LOAD;
          end else begin
            out_d.kind         = bmb_pkg::KIND_SUBMIT;
            out_d.first_index  = bmb_pkg::IndexW'(idx_q);
            out_d.merged_count = bmb_pkg::IndexW'(mlen_q);
            out_d.io_start     = sect_q;
            out_d.io_count     = slen_q;
            out_d.tail_split   = split_q;
            if (split_q) begin
              sect_d      = sect_q + {32'b0, slen_q};
              use_start_d = 1'b0;
            end else begin
              use_start_d = 1'b1;
            end
            if (next < n_q) begin
              idx_d   = next[AddrW-1:0];
              state_d = bmb_pkg::ST_HEAD;
            end else begin
              state_d = bmb_pkg::ST_DONE;
            end
          end
        end
      end

      // Close the batch
      bmb_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.kind  = bmb_pkg::KIND_DONE;
          out_d.last  = 1'b1;
          fill_d      = '0;
          state_d     = bmb_pkg::ST_LOAD;
        end
      end

      default: begin
        state_d = bmb_pkg::ST_LOAD;
      end
    endcase
  end

  // Drive the result channel from the output register
  assign res_o.valid           = out_valid_q;
  assign res_o.result_kind     = out_q.kind;
  assign res_o.first_index     = out_q.first_index;
  assign res_o.merged_count    = out_q.merged_count;
  assign res_o.io_start_sector = out_q.io_start;
  assign res_o.io_sector_count = out_q.io_count;
  assign res_o.tail_split      = out_q.tail_split;
  assign res_o.remain_index    = out_q.remain_index;
  assign res_o.resume_sector   = out_q.resume;
  assign res_o.last            = out_q.last;

endmodule

### src/block_request_merge_batcher_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// req_i     in   valid/ready    one block request (start, count, direction, batch flags)
// res_o     out  valid/ready    one submit IO, or the batch end with optional remainder
// cfg_*     in   write enable   max_merge_sectors
//
// Requests load one per cycle into the request store; the item with batch_last
// starts the scan and the block takes no item until the final result is registered.
// The scan uses one store read port: each IO opens through ST_HEAD and closes in
// ST_EMIT, with ST_RUN examining the requests of a run (merged or not) one by one;
// ST_HEAD_RD starts the scan; ST_DONE or a held-back remainder ends the batch.
// Reset clears the control state only; the store needs no clearing pass.
// A stalled result register stalls the scan; nothing is dropped.

module block_request_merge_batcher_top #(
  parameter int unsigned MAX_BATCH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  bmb_req_if.sink     req_i,
  bmb_res_if.source   res_o
);

  localparam int unsigned AddrW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int unsigned CntW  = $clog2(MAX_BATCH + 1);

  logic [15:0]      max_merge_q;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  bmb_pkg::entry_t  wr_data;
  logic [AddrW-1:0] rd_addr;
  bmb_pkg::entry_t  rd_data;

  // Hold the merge limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_merge_q <= 16'd256;
    end else if (cfg_we_i) begin
      max_merge_q <= cfg_wdata_i;
    end
  end

  bmb_store #(
    .Depth (MAX_BATCH),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  bmb_ctrl #(
    .MaxBatch (MAX_BATCH),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_merge_i (max_merge_q),
    .req_i       (req_i),
    .res_o       (res_o),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  // The closing item of a batch stops intake for the scan
  a_last_stops_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready && req_i.batch_last |=> !req_i.ready)
    else $error("intake open right after batch end");

  // Only batch end results carry last
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.last |-> res_o.result_kind != bmb_pkg::KIND_SUBMIT)
    else $error("submit item marked last");

  // A submit covers at least one request and never ends the batch
  a_submit_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.result_kind == bmb_pkg::KIND_SUBMIT |->
      res_o.merged_count != '0 && !res_o.last)
    else $error("malformed submit item");

  // A remainder result carries no IO description
  a_remain_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.result_kind == bmb_pkg::KIND_REMAIN |->
      res_o.merged_count == '0 && res_o.io_sector_count == '0)
    else $error("remainder item carries IO fields");

endmodule
